// ===== rtl/bitmap_row_shear_unit_assert.svh =====
// Assertion macros used by the bitmap row shear top level.
`ifndef BITMAP_ROW_SHEAR_UNIT_ASSERT_SVH
`define BITMAP_ROW_SHEAR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BRS_ASSERT_IMPLY(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bitmap_row_shear_unit: implication check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define BRS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bitmap_row_shear_unit: next-cycle check failed");

`endif

// ===== rtl/brs_pkg.sv =====
// Shared constants for the bitmap row shear block.
package brs_pkg;

    localparam int PIXEL_W       = 8;
    localparam int SHEAR_W       = 7;
    localparam int BYTE_SHIFT_W  = SHEAR_W - 3;
    localparam int BIT_SHIFT_W   = 3;
    localparam int DIV_CNT_W     = $clog2(SHEAR_W);
    localparam int BPR_CFG_W     = 5;
    localparam int ROWS_CFG_W    = 7;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_IDX_W     = 2;

    localparam int MAX_ROW_BYTES_DEF = 16;
    localparam int MAX_ROWS_DEF      = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_PIXELS  = 2'd2;

endpackage

// ===== rtl/bitmap_row_shear_unit.sv =====
// Top level of the bitmap row shear block: sequencer, counters and output register.
//
// Pixel bytes of a 1-bit MSB-first glyph arrive on in_valid/in_ready, row by
// row, one byte per transfer; the sheared byte for the same position leaves on
// out_valid/out_ready together with end_of_row and end_of_glyph.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle:
// index 0 bytes per row, 1 row count, 2 shear of the top row in pixels.
// The block takes one byte at a time. A byte that is not the first of its row
// goes through the write into the row buffer, the registered read of the two
// source bytes, and the merge into the output register. For the first byte
// of a row with a nonzero shift the row shift is found first, by a multiply
// and a seven-step restoring divide in the row shift unit. A plain byte's
// result passes the registered read and the output register before it shows
// on the outputs. The output register holds a finished result while the
// receiver stalls, and the next byte is taken meanwhile; a second result waits
// in the sequencer until the output register is free.
// Reset clears the row and byte counters, the row shift and the configuration
// (one byte per row, one row, no shear). The row buffer is not cleared.
module bitmap_row_shear_unit
    import brs_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_W-1:0]    pixel_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_W-1:0]    sheared_byte,
    output logic                  end_of_row,
    output logic                  end_of_glyph,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "bitmap_row_shear_unit_assert.svh"

    localparam int BYTE_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int BPR_W  = ($clog2(MAX_ROW_BYTES + 1) > BPR_CFG_W) ?
                            $clog2(MAX_ROW_BYTES + 1) : BPR_CFG_W;
    localparam int RC_W   = ($clog2(MAX_ROWS + 1) > ROWS_CFG_W) ?
                            $clog2(MAX_ROWS + 1) : ROWS_CFG_W;
    localparam int IDX_W  = (BYTE_W > BYTE_SHIFT_W) ? BYTE_W : BYTE_SHIFT_W;
    localparam int BACK_W = BIT_SHIFT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WAIT  = 5'b00100,
        S_READ  = 5'b01000,
        S_COMP  = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic [BPR_CFG_W-1:0]  bytes_per_row_reg;
    logic [ROWS_CFG_W-1:0] row_count_reg;
    logic [SHEAR_W-1:0]    shear_pixels_reg;

    logic [BYTE_W-1:0]     byte_idx_reg;
    logic [ROW_W-1:0]      row_idx_reg;
    logic [BYTE_W-1:0]     byte_cur_reg;
    logic [SHEAR_W-1:0]    shift_reg;
    logic [ROW_W-1:0]      dist_reg;
    logic                  last_byte_reg;
    logic                  last_glyph_reg;
    logic                  in_range_reg;
    logic                  has_prev_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PIXEL_W-1:0]    out_byte_reg;
    logic                  out_eor_reg;
    logic                  out_eog_reg;

    logic [BPR_W-1:0]      bpr_ext;
    logic [BPR_W-1:0]      bpr_eff;
    logic [RC_W-1:0]       rows_ext;
    logic [RC_W-1:0]       rows_eff;
    logic [ROW_W-1:0]      rows_m1;
    logic                  last_byte;
    logic                  last_row;
    logic                  shift_zero;
    logic                  accept;
    logic                  load;

    logic [IDX_W-1:0]      byte_sh;
    logic [IDX_W-1:0]      cur_ext;
    logic [IDX_W-1:0]      src;
    logic                  in_range;
    logic                  has_prev;
    logic [BYTE_W-1:0]     addr_a;
    logic [BYTE_W-1:0]     addr_b;
    logic [BIT_SHIFT_W-1:0] bit_sh;
    logic [BACK_W-1:0]     back_sh;
    logic [PIXEL_W-1:0]    rd_data_a;
    logic [PIXEL_W-1:0]    rd_data_b;
    logic [PIXEL_W-1:0]    lo_part;
    logic [PIXEL_W-1:0]    hi_part;
    logic [PIXEL_W-1:0]    merged;

    logic                  div_start;
    logic                  div_done;
    logic [SHEAR_W-1:0]    div_quotient;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_per_row_reg <= BPR_CFG_W'(1);
            row_count_reg     <= ROWS_CFG_W'(1);
            shear_pixels_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BYTES_PER_ROW: bytes_per_row_reg <= cfg_data[BPR_CFG_W-1:0];
                REG_ROW_COUNT:     row_count_reg     <= cfg_data[ROWS_CFG_W-1:0];
                REG_SHEAR_PIXELS:  shear_pixels_reg  <= cfg_data[SHEAR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective geometry: zero counts as one, large values saturate.
    always_comb
    begin
        bpr_ext = BPR_W'(bytes_per_row_reg);
        if (bpr_ext == '0)
        begin
            bpr_eff = BPR_W'(1);
        end
        else if (bpr_ext > BPR_W'(MAX_ROW_BYTES))
        begin
            bpr_eff = BPR_W'(MAX_ROW_BYTES);
        end
        else
        begin
            bpr_eff = bpr_ext;
        end

        rows_ext = RC_W'(row_count_reg);
        if (rows_ext == '0)
        begin
            rows_eff = RC_W'(1);
        end
        else if (rows_ext > RC_W'(MAX_ROWS))
        begin
            rows_eff = RC_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_ext;
        end
    end

    assign rows_m1    = ROW_W'(rows_eff - RC_W'(1));
    assign last_byte  = BPR_W'(BPR_W'(byte_idx_reg) + BPR_W'(1)) >= bpr_eff;
    // A row at or past the last one has no shift, which also covers one-row glyphs.
    assign last_row   = row_idx_reg >= rows_m1;
    assign shift_zero = (shear_pixels_reg == '0) || last_row;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == S_COMP) && (!out_valid_reg || out_ready);
    assign div_start = (state_reg == S_START);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((byte_idx_reg == '0) && !shift_zero)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_START: state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_COMP;
            S_COMP:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            byte_idx_reg <= '0;
            row_idx_reg  <= '0;
            shift_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (last_byte)
                begin
                    byte_idx_reg <= '0;
                    row_idx_reg  <= last_row ? '0 : ROW_W'(row_idx_reg + 1'b1);
                end
                else
                begin
                    byte_idx_reg <= BYTE_W'(byte_idx_reg + 1'b1);
                end
                if ((byte_idx_reg == '0) && shift_zero)
                begin
                    shift_reg <= '0;
                end
            end
            else if ((state_reg == S_WAIT) && div_done)
            begin
                shift_reg <= div_quotient;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_cur_reg   <= byte_idx_reg;
            dist_reg       <= ROW_W'(rows_m1 - row_idx_reg);
            last_byte_reg  <= last_byte;
            last_glyph_reg <= last_byte && last_row;
        end
        if (state_reg == S_READ)
        begin
            in_range_reg <= in_range;
            has_prev_reg <= has_prev;
        end
    end

    // Source bytes: the whole-byte part of the shift picks the entry, the
    // bit part pulls the low pixels of the entry to its left.
    assign byte_sh  = IDX_W'(shift_reg[SHEAR_W-1:BIT_SHIFT_W]);
    assign bit_sh   = shift_reg[BIT_SHIFT_W-1:0];
    assign cur_ext  = IDX_W'(byte_cur_reg);
    assign in_range = byte_sh <= cur_ext;
    assign src      = IDX_W'(cur_ext - byte_sh);
    assign has_prev = (src != '0) && (bit_sh != '0);
    assign addr_a   = src[BYTE_W-1:0];
    assign addr_b   = has_prev ? BYTE_W'(src - IDX_W'(1)) : '0;

    brs_row_buf #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (BYTE_W)
    ) u_row_buf (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (byte_idx_reg),
        .wr_data   (pixel_byte),
        .rd_en     (state_reg == S_READ),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    brs_div #(
        .ROW_W (ROW_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .shear    (shear_pixels_reg),
        .row_dist (dist_reg),
        .divisor  (rows_m1),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign back_sh = BACK_W'(PIXEL_W) - {1'b0, bit_sh};
    assign lo_part = rd_data_a >> bit_sh;
    assign hi_part = has_prev_reg ? PIXEL_W'(rd_data_b << back_sh) : '0;
    assign merged  = in_range_reg ? (lo_part | hi_part) : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= merged;
            out_eor_reg  <= last_byte_reg;
            out_eog_reg  <= last_glyph_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sheared_byte = out_byte_reg;
    assign end_of_row   = out_eor_reg;
    assign end_of_glyph = out_eog_reg;

    `BRS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
    `BRS_ASSERT_IMPLY(a_done_only_in_wait, div_done, state_reg == S_WAIT)
    `BRS_ASSERT_IMPLY(a_quotient_bound, div_done, div_quotient <= shear_pixels_reg)
    `BRS_ASSERT_NEXT(a_result_loaded, load, out_valid && in_ready)

endmodule

// ===== rtl/brs_div.sv =====
// Row shift unit: one multiply, then a restoring divide one quotient bit per cycle.
module brs_div
    import brs_pkg::*;
#(
    parameter int ROW_W = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SHEAR_W-1:0] shear,
    input  logic [ROW_W-1:0]   row_dist,
    input  logic [ROW_W-1:0]   divisor,
    output logic               done,
    output logic [SHEAR_W-1:0] quotient
);

    localparam int PROD_W = SHEAR_W + ROW_W;

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ROW_W-1:0]     rem_reg;
    logic [ROW_W-1:0]     rem_next;
    logic [SHEAR_W-1:0]   quo_reg;
    logic [ROW_W-1:0]     divisor_reg;
    logic [PROD_W-1:0]    prod;
    logic [ROW_W:0]       trial;
    logic [ROW_W:0]       diff;
    logic                 ge;

    // The quotient never exceeds shear, so the top part of the product is
    // already below the divisor and only SHEAR_W steps remain.
    assign prod  = PROD_W'(shear) * PROD_W'(row_dist);
    assign trial = {rem_reg, quo_reg[SHEAR_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        if (ge)
        begin
            rem_next = diff[ROW_W-1:0];
        end
        else
        begin
            rem_next = trial[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(SHEAR_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= DIV_CNT_W'(cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= prod[PROD_W-1:SHEAR_W];
            quo_reg     <= prod[SHEAR_W-1:0];
            divisor_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SHEAR_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/brs_row_buf.sv =====
// Row buffer: one write port and two registered read ports.
module brs_row_buf
    import brs_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [PIXEL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr_a,
    input  logic [ADDR_W-1:0]  rd_addr_b,
    output logic [PIXEL_W-1:0] rd_data_a,
    output logic [PIXEL_W-1:0] rd_data_b
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_a_reg;
    logic [PIXEL_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
